// ----- hdl/lcstb_pkg.sv -----
`timescale 1ns / 1ps
package lcstb_pkg;

  typedef struct packed {
    logic [15:0] item_id;
    logic [6:0]  level;
    logic [7:0]  chance;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_item_id;
    logic [6:0]  out_level;
    logic [6:0]  weight;
    logic        status;
    logic        dropped;
    logic        last_out;
  } out_item_t;

  // classified record passed from front to back
  typedef struct packed {
    logic        keep;
    logic        last;
    logic [15:0] item_id;
    logic [6:0]  level;
    logic [6:0]  weight;
  } cmd_t;

  localparam int unsigned FullWeight = 100;

  // quotient 100 / d for d 1..255 found by counting multiples, entry 0 unused
  function automatic logic [255:0][6:0] build_weights();
    logic [255:0][6:0] t;
    t = '0;
    for (int d = 1; d < 256; d++) begin
      for (int k = 1; k <= int'(FullWeight); k++) begin
        if (k * d <= int'(FullWeight)) t[d] = 7'(k);
      end
    end
    return t;
  endfunction

  localparam logic [255:0][6:0] WeightTable = build_weights();

  // 100 / chance for chance 1..255, constant table
  function automatic logic [6:0] weight_of(input logic [7:0] chance);
    return WeightTable[chance];
  endfunction

endpackage

// ----- hdl/lcstb_ram.sv -----
`timescale 1ns / 1ps
module lcstb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/lcstb_front.sv -----
`timescale 1ns / 1ps
module lcstb_front #(
  parameter int LEVELS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  lcstb_pkg::in_item_t in_item,
  input  logic               push,
  output logic               full,
  output lcstb_pkg::cmd_t    cmd,
  output logic               cmd_valid,
  input  logic               cmd_ready
);
  import lcstb_pkg::*;

  // two-entry queue of classified records
  cmd_t q [2];
  logic [1:0] cnt;
  logic rd_ptr, wr_ptr;
  cmd_t c;
  logic wr, rd;

  always_comb begin
    c.keep    = (in_item.chance != 8'd0) && ({2'b0, in_item.level} < 9'(LEVELS));
    c.last    = in_item.last_in;
    c.item_id = in_item.item_id;
    c.level   = in_item.level;
    c.weight  = weight_of(in_item.chance);
  end

  assign full = (cnt == 2'd2);
  assign wr = push && !full;
  assign cmd_valid = (cnt != 2'd0);
  assign rd = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wr_ptr] <= c;
    end
    if (rst) begin
      cnt <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule

// ----- hdl/lcstb_back.sv -----
`timescale 1ns / 1ps
module lcstb_back #(
  parameter int LEVELS = 128,
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  lcstb_pkg::cmd_t     cmd,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output lcstb_pkg::out_item_t result,
  output logic                empty,
  input  logic                pop
);
  import lcstb_pkg::*;

  localparam int LW = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = 30;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_RMW   = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_PFX   = 7'b0001000,
    S_SCAT  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_CLR   = 7'b1000000
  } state_t;

  state_t state;
  cmd_t cur;
  logic [CW-1:0] count;
  logic overflow;
  logic [LW:0] li;
  logic [CW:0] ei;
  logic [CW:0] run;
  logic ph;

  // histogram / start table memory, CW+1-bit counts later overwritten by start positions
  logic hw;
  logic [LW-1:0] hwa, hra;
  logic [CW:0] hwd, hrd;
  // valid bits: entry not valid reads as zero
  logic [LEVELS-1:0] hval;
  logic hval_r;
  logic [CW:0] hcur;

  lcstb_ram #(.WIDTH(CW + 1), .DEPTH(LEVELS)) u_hist (
    .clk(clk), .we(hw), .waddr(hwa), .wdata(hwd), .raddr(hra), .rdata(hrd)
  );

  logic aw;
  logic [AW-1:0] awa, ara;
  logic [RW-1:0] awd, ard;
  lcstb_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_arr (
    .clk(clk), .we(aw), .waddr(awa), .wdata(awd), .raddr(ara), .rdata(ard)
  );

  logic sw;
  logic [AW-1:0] swa, sra;
  logic [RW-1:0] swd, srd;
  lcstb_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_srt (
    .clk(clk), .we(sw), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd)
  );

  logic [6:0] lvl0_cnt;
  logic obuf_v;
  out_item_t obuf;
  logic scat_pipe;
  logic [LW-1:0] scat_lvl;
  logic [RW-1:0] scat_rec;
  logic [LW-1:0] rec_lvl;

  assign hcur = hval_r ? hrd : '0;
  assign cmd_ready = (state == S_LOAD);
  assign empty = !obuf_v;
  assign result = obuf;
  assign rec_lvl = LW'(ard[13:7]);

  always_comb begin
    hw = 1'b0; hwa = LW'(cur.level); hwd = hcur + 1'b1;
    hra = LW'(cmd.level);
    aw = 1'b0; awa = count[AW-1:0]; awd = {cur.item_id, cur.level, cur.weight};
    ara = ei[AW-1:0];
    sw = 1'b0; swa = hcur[AW-1:0]; swd = scat_rec;
    sra = ei[AW-1:0];
    unique case (state)
      S_RMW: begin
        hw = cur.keep && (count < CW'(CAPACITY));
        aw = hw;
      end
      S_PFX: begin
        hra = li[LW-1:0];
        hwa = li[LW-1:0];
        hwd = run;
        hw = ph;
      end
      S_SCAT: begin
        hra = rec_lvl;
        hwa = scat_lvl;
        hwd = hcur + 1'b1;
        hw = scat_pipe;
        sw = scat_pipe && (hcur < (CW+1)'(CAPACITY));
        if (scat_pipe) hra = scat_lvl;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hval_r <= hval[hra];
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      overflow <= 1'b0;
      hval <= '0;
      obuf_v <= 1'b0;
      lvl0_cnt <= '0;
      scat_pipe <= 1'b0;
      ph <= 1'b0;
    end else begin
      if (obuf_v && pop) obuf_v <= 1'b0;
      unique case (state)
        S_LOAD: if (cmd_valid) begin
          cur <= cmd;
          state <= S_RMW;
        end
        S_RMW: begin
          if (cur.keep) begin
            if (count < CW'(CAPACITY)) begin
              count <= count + 1'b1;
              hval[LW'(cur.level)] <= 1'b1;
              if (cur.level == 7'd0) lvl0_cnt <= lvl0_cnt + 1'b1;
            end else begin
              overflow <= 1'b1;
            end
          end
          state <= cur.last ? S_CHK : S_LOAD;
        end
        S_CHK: if (!obuf_v) begin
          if (lvl0_cnt == 7'd0) begin
            obuf <= '{out_item_id: '0, out_level: '0, weight: '0,
                      status: 1'b1, dropped: overflow, last_out: 1'b1};
            obuf_v <= 1'b1;
            state <= S_CLR;
          end else begin
            li <= '0; run <= '0; ph <= 1'b0;
            state <= S_PFX;
          end
        end
        S_PFX: begin
          // read level li, next cycle write its start and advance the sum
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            hval[li[LW-1:0]] <= 1'b1;
            run <= run + hcur;
            ph <= 1'b0;
            if (li == (LW+1)'(LEVELS - 1)) begin
              ei <= '0; scat_pipe <= 1'b0; ph <= 1'b0;
              state <= S_SCAT;
            end else begin
              li <= li + 1'b1;
            end
          end
        end
        S_SCAT: begin
          // ph0: arrival read issued; ph1: record out, start read issued;
          // ph2: write sorted and bump start
          if (!ph && !scat_pipe) begin
            ph <= 1'b1;
          end else if (ph) begin
            scat_rec <= ard;
            scat_lvl <= rec_lvl;
            scat_pipe <= 1'b1;
            ph <= 1'b0;
          end else begin
            scat_pipe <= 1'b0;
            if (ei + 1'b1 == (CW+1)'(count)) begin
              ei <= '0; ph <= 1'b0;
              state <= S_EMIT;
            end else begin
              ei <= ei + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (!obuf_v) begin
            obuf <= '{out_item_id: srd[29:14], out_level: srd[13:7], weight: srd[6:0],
                      status: 1'b0,
                      dropped: (ei + 1'b1 == (CW+1)'(count)) ? overflow : 1'b0,
                      last_out: (ei + 1'b1 == (CW+1)'(count))};
            obuf_v <= 1'b1;
            ph <= 1'b0;
            if (ei + 1'b1 == (CW+1)'(count)) state <= S_CLR;
            else ei <= ei + 1'b1;
          end
        end
        S_CLR: begin
          count <= '0;
          overflow <= 1'b0;
          hval <= '0;
          lvl0_cnt <= '0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
      // in the prefix pass the valid bit of the level not yet rewritten must stay
      // as count valid; it was set above when rewritten
    end
  end
endmodule

// ----- hdl/level_counting_sort_table_builder.sv -----
`timescale 1ns / 1ps
// Stable counting sort of (item id, level, chance) records. The back end loads
// each record, then does one histogram read-modify-write through a registered
// RAM; a small queue in front absorbs pushes. On the record marked last the
// block runs prefix sums over the levels, a scatter of the stored records and a
// readout that waits for pops, during which the back end takes no new record
// and the front queue holds at most two. With no stored level-0 record it emits
// one status record instead. Weight is 100 / chance from a constant table.
module level_counting_sort_table_builder #(
  parameter int LEVELS = 128,
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lcstb_pkg::in_item_t  in_item,
  input  logic                 push,
  output logic                 full,
  output lcstb_pkg::out_item_t result,
  output logic                 empty,
  input  logic                 pop
);
  import lcstb_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  lcstb_front #(.LEVELS(LEVELS)) u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  lcstb_back #(.LEVELS(LEVELS), .CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .result(result), .empty(empty), .pop(pop)
  );
endmodule
